/* hdl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared types, opcodes, state encoding and default sizes for the execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

   // Default sizes.
   localparam int unsigned STACK_DEPTH_DEF = 64;
   localparam int unsigned INDEX_BITS_DEF  = 16;

   // Fixed field widths.
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned MODE_W   = 5;
   localparam int unsigned IDX_W    = 16;
   localparam int unsigned TARGET_W = 17;
   localparam int unsigned DEPTH_W  = 7;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

   // Instruction opcodes.
   typedef enum logic [MODE_W-1:0] {
      OP_POP    = 5'd0,
      OP_PUSH   = 5'd1,
      OP_DUP    = 5'd2,
      OP_ADD    = 5'd3,
      OP_SUB    = 5'd4,
      OP_MUL    = 5'd5,
      OP_DIV    = 5'd6,
      OP_SWAP   = 5'd7,
      OP_PRINTC = 5'd8,
      OP_NOP    = 5'd9,
      OP_HALT   = 5'd10,
      OP_INC    = 5'd11,
      OP_DEC    = 5'd12,
      OP_JMP    = 5'd13,
      OP_JZ     = 5'd14,
      OP_JNZ    = 5'd15,
      OP_CALL   = 5'd16,
      OP_RET    = 5'd17
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_WB,
      ST_WB2,
      ST_DONE
   } state_type;

   // One instruction item.
   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] operand;
      logic [IDX_W-1:0]         instr_index;
   } req_type;

   // One result item.
   typedef struct packed {
      logic                     jump_valid;
      logic [TARGET_W-1:0]      jump_target;
      logic signed [DATA_W-1:0] top_value;
      logic [DEPTH_W-1:0]       stack_depth;
      logic                     char_valid;
      logic [CHAR_W-1:0]        char_out;
      logic                     overflow;
   } rsp_type;

endpackage

/* hdl/stack_machine_execute_unit.sv */
// Each accepted item steps through EXEC, DIV (divide only), WB, WB2 (swap only) and DONE;
// no new item is taken until DONE hands the result on, and DONE waits while it is stalled.
// Swap writes the single write port twice; divide uses a 32-step restoring divider.
// The stack lives in a memory with one write and two registered read ports.
// Reset (synchronous, active high) empties the stack and clears the return
// register; stack memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Runs one stack-machine instruction per item on a bounded data stack under
// a small sequencer and returns one result item per instruction.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit #(
   parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
   parameter int unsigned INDEX_BITS  = smx_pkg::INDEX_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  smx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output smx_pkg::rsp_type rsp_data
);
   import smx_pkg::*;

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
   localparam logic [DATA_W:0] CALL_LIMIT = (DATA_W + 1)'(64'd1 << INDEX_BITS);
   localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
      IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

   // Control registers.
   state_type           state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [TARGET_W-1:0] ret_ff, ret_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   req_type             req_ff, req_in;
   logic                wr_en_ff, wr_en_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic [DATA_W-1:0]   wr_data_ff, wr_data_in;
   logic [DATA_W-1:0]   wr2_data_ff, wr2_data_in;
   logic                swap_ff, swap_in;
   logic [CW-1:0]       cnt_next_ff, cnt_next_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic [DATA_W-1:0]   div_rem_ff, div_rem_in;
   logic [DATA_W-1:0]   div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Stack memory and its registered read data.
   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0]   rd_t_ff, rd_n_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [DATA_W-1:0]   mem_wdata;

   // Address and status helpers.
   logic [CW-1:0]       cnt_m1, cnt_m2;
   logic [AW-1:0]       addr_t, addr_n;
   logic                accept, out_free, has_one, has_two, is_full, div_last;

   // Execute decisions.
   logic                ex_we, ex_swap, ex_jv, ex_cv, ex_ovf, ex_div_go;
   logic [AW-1:0]       ex_waddr;
   logic [DATA_W-1:0]   ex_wdata, ex_top, mul_res;
   logic [CW-1:0]       ex_cnt;
   logic [TARGET_W-1:0] ex_tgt, ex_ret;
   logic [CHAR_W-1:0]   ex_ch;
   logic                jump_ok, call_ok, take;
   op_type              op;

   // Divider step.
   logic [DATA_W:0]     div_sh, div_diff;
   logic                div_ge;
   logic [DATA_W-1:0]   quo_step;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cnt_m1   = cnt_ff - CW'(1);
   assign cnt_m2   = cnt_ff - CW'(2);
   assign addr_t   = cnt_m1[AW-1:0];
   assign addr_n   = cnt_m2[AW-1:0];
   assign has_one  = (cnt_ff != '0);
   assign has_two  = (cnt_ff >= CW'(2));
   assign is_full  = (cnt_ff == FULL_CNT);
   assign div_last = (div_cnt_ff == {DIV_CNT_W{1'b1}});
   assign op       = op_type'(req_ff.mode);

   // Stack memory: one write port, two read ports at top and next.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_t_ff <= stack_mem[addr_t];
      rd_n_ff <= stack_mem[addr_n];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ret_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      wr_en_ff    <= wr_en_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
      wr2_data_ff <= wr2_data_in;
      swap_ff     <= swap_in;
      cnt_next_ff <= cnt_next_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: state_in = ex_div_go ? ST_DIV : ST_WB;
         ST_DIV:  if (div_last) state_in = ST_WB;
         ST_WB:   state_in = swap_ff ? ST_WB2 : ST_DONE;
         ST_WB2:  state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and memory write port.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = wr_data_ff;
      unique case (state_ff)
         ST_WB:   mem_we = wr_en_ff;
         ST_WB2: begin
            mem_we    = 1'b1;
            mem_waddr = addr_n;
            mem_wdata = wr2_data_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // Execute: decide the stack update and result fields from top and next.
   assign mul_res = rd_t_ff * rd_n_ff;
   assign jump_ok = has_one && !req_ff.operand[DATA_W-1] &&
                    ({1'b0, req_ff.operand} <= (DATA_W + 1)'(cnt_ff));
   assign call_ok = !req_ff.operand[DATA_W-1] &&
                    ({1'b0, req_ff.operand} <= CALL_LIMIT);

   always_comb begin
      ex_we     = 1'b0;
      ex_swap   = 1'b0;
      ex_jv     = 1'b0;
      ex_cv     = 1'b0;
      ex_ovf    = 1'b0;
      ex_div_go = 1'b0;
      ex_waddr  = addr_t;
      ex_wdata  = rd_t_ff;
      ex_top    = rd_t_ff;
      ex_cnt    = cnt_ff;
      ex_tgt    = '0;
      ex_ret    = ret_ff;
      ex_ch     = '0;
      take      = 1'b0;
      unique case (op)
         OP_POP: begin
            if (has_one) begin
               ex_cnt = cnt_m1;
               ex_top = rd_n_ff;
            end
         end
         OP_PUSH: begin
            if (is_full) begin
               ex_ovf = 1'b1;
            end else begin
               ex_we    = 1'b1;
               ex_waddr = cnt_ff[AW-1:0];
               ex_wdata = req_ff.operand;
               ex_top   = req_ff.operand;
               ex_cnt   = cnt_ff + CW'(1);
            end
         end
         OP_DUP: begin
            if (has_one && is_full) begin
               ex_ovf = 1'b1;
            end else if (has_one) begin
               ex_we    = 1'b1;
               ex_waddr = cnt_ff[AW-1:0];
               ex_cnt   = cnt_ff + CW'(1);
            end
         end
         OP_ADD, OP_SUB, OP_MUL: begin
            if (has_two) begin
               priority case (op)
                  OP_ADD:  ex_wdata = rd_t_ff + rd_n_ff;
                  OP_SUB:  ex_wdata = rd_t_ff - rd_n_ff;
                  default: ex_wdata = mul_res;
               endcase
               ex_we    = 1'b1;
               ex_waddr = addr_n;
               ex_top   = ex_wdata;
               ex_cnt   = cnt_m1;
            end
         end
         OP_DIV: begin
            // A zero divisor leaves the stack as it is.
            if (has_two && (rd_n_ff != '0)) begin
               ex_div_go = 1'b1;
               ex_we     = 1'b1;
               ex_waddr  = addr_n;
               ex_cnt    = cnt_m1;
            end
         end
         OP_SWAP: begin
            if (has_two) begin
               ex_we    = 1'b1;
               ex_swap  = 1'b1;
               ex_wdata = rd_n_ff;
               ex_top   = rd_n_ff;
            end
         end
         OP_PRINTC: begin
            if (has_one) begin
               ex_cv = 1'b1;
               ex_ch = rd_t_ff[CHAR_W-1:0];
            end
         end
         OP_INC, OP_DEC: begin
            if (has_one) begin
               ex_we    = 1'b1;
               ex_wdata = (op == OP_INC) ? rd_t_ff + DATA_W'(1) : rd_t_ff - DATA_W'(1);
               ex_top   = ex_wdata;
            end
         end
         OP_JMP, OP_JZ, OP_JNZ: begin
            take = jump_ok && ((op == OP_JMP) ||
                               ((op == OP_JZ) && (rd_t_ff == '0)) ||
                               ((op == OP_JNZ) && (rd_t_ff != '0)));
            if (take) begin
               ex_jv  = 1'b1;
               ex_tgt = req_ff.operand[TARGET_W-1:0];
               if (op != OP_JMP) begin
                  ex_cnt = cnt_m1;
                  ex_top = rd_n_ff;
               end
            end
         end
         OP_CALL: begin
            if (call_ok) begin
               ex_ret = {1'b0, req_ff.instr_index & IDX_MASK} + TARGET_W'(1);
               ex_jv  = 1'b1;
               ex_tgt = req_ff.operand[TARGET_W-1:0];
            end
         end
         OP_RET: begin
            ex_jv  = 1'b1;
            ex_tgt = ret_ff;
         end
         default: ex_we = 1'b0;
      endcase
   end

   // Divider: one restoring step a cycle, quotient shifts into div_quo.
   assign div_sh   = {div_rem_ff, div_quo_ff[DATA_W-1]};
   assign div_diff = div_sh - {1'b0, rd_n_ff};
   assign div_ge   = (div_sh >= {1'b0, rd_n_ff});
   assign quo_step = {div_quo_ff[DATA_W-2:0], div_ge};

   // Datapath next values.
   always_comb begin
      req_in       = req_ff;
      wr_en_in     = wr_en_ff;
      wr_addr_in   = wr_addr_ff;
      wr_data_in   = wr_data_ff;
      wr2_data_in  = wr2_data_ff;
      swap_in      = swap_ff;
      cnt_next_in  = cnt_next_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      cnt_in       = cnt_ff;
      ret_in       = ret_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) req_in = req_data;
         end
         ST_EXEC: begin
            wr_en_in    = ex_we;
            wr_addr_in  = ex_waddr;
            wr_data_in  = ex_wdata;
            wr2_data_in = rd_t_ff;
            swap_in     = ex_swap;
            cnt_next_in = ex_cnt;
            ret_in      = ex_ret;
            res_in.jump_valid  = ex_jv;
            res_in.jump_target = ex_tgt;
            res_in.top_value   = (ex_cnt == '0) ? '0 : ex_top;
            res_in.stack_depth = DEPTH_W'(ex_cnt);
            res_in.char_valid  = ex_cv;
            res_in.char_out    = ex_ch;
            res_in.overflow    = ex_ovf;
            div_rem_in  = '0;
            div_quo_in  = rd_t_ff;
            div_cnt_in  = '0;
         end
         ST_DIV: begin
            div_rem_in = div_ge ? div_diff[DATA_W-1:0] : div_sh[DATA_W-1:0];
            div_quo_in = quo_step;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_last) begin
               wr_data_in       = quo_step;
               res_in.top_value = quo_step;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               cnt_in       = cnt_next_ff;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/smx_checker.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit checker
// Port-level assertions on the execute unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module smx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input smx_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input smx_pkg::rsp_type rsp_data
);
   import smx_pkg::*;

   // The unit works on one item at a time after accepting it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while the previous one was still starting");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

   // No jump means a zero target.
   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.jump_valid) |-> (rsp_data.jump_target == '0))
      else $error("jump target set without a jump");

   // A character is only reported by printc; otherwise the byte is zero.
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.char_valid) |-> (rsp_data.char_out == '0))
      else $error("character byte set without a character");

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (.*);

/* tb/tb_stack_machine_execute_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Sends instruction items through the request channel and checks every
// result item against a stack model kept inside the testbench. A directed
// opening covers empty-stack cases, divide by zero, jump and call limits and
// every opcode. Random programs follow under three idling profiles.
// ----------------------------------------------------------------------------
module tb_stack_machine_execute_unit;
   import smx_pkg::*;

   localparam int          STACK_SIZE     = STACK_DEPTH_DEF;
   localparam logic [31:0] CALL_LIMIT     = 32'h1 << INDEX_BITS_DEF;
   localparam logic [4:0]  OP_FIRST_SPARE = 5'd18;
   localparam logic [4:0]  OP_LAST_SPARE  = 5'd31;
   localparam int          RANDOM_ITEMS   = 700;
   localparam int          STALL_LIMIT    = 5000;
   localparam int          SETTLE_CYCLES  = 20;
   localparam int          REPORT_LIMIT   = 10;

   // One queued instruction with the idling profile it is sent under.
   typedef struct {
      req_type item;
      int      phase;
      bit      hold;
   } instr_slot_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idle percentages per phase for the sender and the receiver.
   int send_idle_pct[3] = '{27, 66, 0};
   int recv_idle_pct[3] = '{66, 27, 0};

   instr_slot_type pending_instr[$];
   rsp_type        predicted_rsp[$];
   int             cur_phase = 0;
   int             gen_phase = 0;
   bit             hold_next = 1'b0;

   // Stack model state.
   logic [31:0] stk_mem [STACK_SIZE];
   int          stk_depth = 0;
   logic [16:0] ret_idx   = '0;

   // Run statistics.
   int items_sent    = 0;
   int results_seen  = 0;
   int mismatch_count = 0;
   int jumps_seen    = 0;
   int overflows_seen = 0;
   int chars_seen    = 0;
   int stall_cycles  = 0;

   stack_machine_execute_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Execute one instruction on the stack model and return its result item.
   function automatic rsp_type exec_instr(input req_type item);
      rsp_type     res;
      logic [31:0] opnd;
      logic [31:0] top_w;
      logic [31:0] nxt_w;
      logic [31:0] alu_w;
      logic        take;
      res   = '0;
      opnd  = item.operand;
      top_w = '0;
      nxt_w = '0;
      alu_w = '0;
      if (stk_depth > 0) top_w = stk_mem[stk_depth - 1];
      if (stk_depth > 1) nxt_w = stk_mem[stk_depth - 2];
      case (item.mode)
         OP_POP: begin
            if (stk_depth > 0) stk_depth--;
         end
         OP_PUSH: begin
            if (stk_depth < STACK_SIZE) begin
               stk_mem[stk_depth] = opnd;
               stk_depth++;
            end else begin
               res.overflow = 1'b1;
            end
         end
         OP_DUP: begin
            if (stk_depth > 0) begin
               if (stk_depth < STACK_SIZE) begin
                  stk_mem[stk_depth] = top_w;
                  stk_depth++;
               end else begin
                  res.overflow = 1'b1;
               end
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            // A divide by zero leaves the stack as it was.
            if (stk_depth >= 2 && !(item.mode == OP_DIV && nxt_w == '0)) begin
               case (item.mode)
                  OP_ADD:  alu_w = top_w + nxt_w;
                  OP_SUB:  alu_w = top_w - nxt_w;
                  OP_MUL:  alu_w = top_w * nxt_w;
                  default: alu_w = top_w / nxt_w;
               endcase
               stk_depth--;
               stk_mem[stk_depth - 1] = alu_w;
            end
         end
         OP_SWAP: begin
            if (stk_depth >= 2) begin
               stk_mem[stk_depth - 1] = nxt_w;
               stk_mem[stk_depth - 2] = top_w;
            end
         end
         OP_PRINTC: begin
            if (stk_depth > 0) begin
               res.char_valid = 1'b1;
               res.char_out   = top_w[7:0];
            end
         end
         OP_INC: begin
            if (stk_depth > 0) stk_mem[stk_depth - 1] = top_w + 32'd1;
         end
         OP_DEC: begin
            if (stk_depth > 0) stk_mem[stk_depth - 1] = top_w - 32'd1;
         end
         OP_JMP, OP_JZ, OP_JNZ: begin
            // The target must lie within 0..depth and the stack must hold an entry.
            if (stk_depth > 0 && !opnd[31] && opnd <= 32'(stk_depth)) begin
               take = (item.mode == OP_JMP) ||
                      (item.mode == OP_JZ && top_w == '0) ||
                      (item.mode == OP_JNZ && top_w != '0);
               if (take) begin
                  if (item.mode != OP_JMP) stk_depth--;
                  res.jump_valid  = 1'b1;
                  res.jump_target = opnd[16:0];
               end
            end
         end
         OP_CALL: begin
            if (!opnd[31] && opnd <= CALL_LIMIT) begin
               ret_idx         = 17'(item.instr_index) + 17'd1;
               res.jump_valid  = 1'b1;
               res.jump_target = opnd[16:0];
            end
         end
         OP_RET: begin
            res.jump_valid  = 1'b1;
            res.jump_target = ret_idx;
         end
         default: begin
         end
      endcase
      res.top_value   = (stk_depth > 0) ? stk_mem[stk_depth - 1] : '0;
      res.stack_depth = 7'(stk_depth);
      return res;
   endfunction

   // Queue one instruction under the current phase.
   task automatic add_instr(input logic [4:0] mode, input logic [31:0] opnd,
                            input logic [15:0] index);
      instr_slot_type slot;
      slot.item.mode        = mode;
      slot.item.operand     = opnd;
      slot.item.instr_index = index;
      slot.phase            = gen_phase;
      slot.hold             = hold_next;
      hold_next             = 1'b0;
      pending_instr.push_back(slot);
   endtask

   function automatic logic [31:0] push_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) return 32'd0;
      if (sel < 30) return 32'($urandom_range(3));
      if (sel < 35) return 32'h8000_0000;
      if (sel < 40) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Jump and call targets: mostly inside the stack depth, some out of range.
   function automatic logic [31:0] target_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 50) return 32'($urandom_range(12));
      if (sel < 70) return 32'($urandom_range(70));
      if (sel < 80) return $urandom | 32'h8000_0000;
      if (sel < 90) return CALL_LIMIT - 32'd2 + 32'($urandom_range(3));
      return $urandom;
   endfunction

   function automatic logic [15:0] index_value();
      return ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
   endfunction

   task automatic add_random_instr();
      int         sel;
      logic [4:0] mode;
      logic [31:0] opnd;
      sel = $urandom_range(99);
      if (sel < 25)      mode = OP_PUSH;
      else if (sel < 45) mode = 5'($urandom_range(OP_ADD, OP_DIV));
      else if (sel < 55) mode = ($urandom_range(1) != 0) ? OP_SWAP : 5'($urandom_range(OP_DUP));
      else if (sel < 63) mode = ($urandom_range(2) == 0) ? OP_PRINTC :
                                5'($urandom_range(OP_INC, OP_DEC));
      else if (sel < 80) mode = 5'($urandom_range(OP_JMP, OP_JNZ));
      else if (sel < 90) mode = 5'($urandom_range(OP_CALL, OP_RET));
      else if (sel < 95) mode = 5'($urandom_range(OP_NOP, OP_HALT));
      else               mode = 5'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
      if (mode == OP_PUSH)
         opnd = push_value();
      else if (mode inside {OP_JMP, OP_JZ, OP_JNZ, OP_CALL})
         opnd = target_value();
      else
         opnd = $urandom;
      add_instr(mode, opnd, index_value());
   endtask

   // One random program fragment.
   task automatic add_random_segment();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) begin
         // Fill the stack and then push past the top.
         repeat ($urandom_range(58, 66)) add_instr(OP_PUSH, push_value(), index_value());
         add_instr(OP_DUP, $urandom, index_value());
         add_instr(OP_PUSH, push_value(), index_value());
      end else if (sel < 15) begin
         // Empty the stack with pops and arithmetic.
         repeat ($urandom_range(20, 70)) begin
            if ($urandom_range(1) != 0)
               add_instr(OP_POP, $urandom, index_value());
            else
               add_instr(5'($urandom_range(OP_ADD, OP_DIV)), $urandom, index_value());
         end
      end else if (sel < 50) begin
         // A small expression followed by a use of its result.
         add_instr(OP_PUSH, push_value(), index_value());
         add_instr(OP_PUSH, push_value(), index_value());
         add_instr(5'($urandom_range(OP_ADD, OP_DIV)), $urandom, index_value());
         case ($urandom_range(3))
            0:       add_instr(OP_PRINTC, $urandom, index_value());
            1:       add_instr(OP_JZ, 32'($urandom_range(4)), index_value());
            2:       add_instr(OP_JNZ, 32'($urandom_range(4)), index_value());
            default: add_instr(OP_DUP, $urandom, index_value());
         endcase
      end else begin
         repeat ($urandom_range(8, 20)) add_random_instr();
      end
   endtask

   // Driver: offers queued items, idling at random, and runs the model on
   // each accepted item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(exec_instr(req_data));
            items_sent++;
         end
         if (req_valid && !req_ready) begin
            // Keep the item on the bus until it is taken.
         end else if (pending_instr.size() == 0) begin
            req_valid <= 1'b0;
         end else if ((pending_instr[0].hold && predicted_rsp.size() != 0) ||
                      $urandom_range(99) < send_idle_pct[pending_instr[0].phase]) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_instr[0].item;
            cur_phase <= pending_instr[0].phase;
            void'(pending_instr.pop_front());
         end
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch on result %0d, %s: expected 0x%08h, got 0x%08h",
                     results_seen, field, want, got);
      end
   endtask

   // Monitor: stalls at random and compares each result with the oldest
   // prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (predicted_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Result %0d arrived with no instruction pending",
                           results_seen);
            end else begin
               want = predicted_rsp.pop_front();
               check_field("jump_valid",  want.jump_valid,  rsp_data.jump_valid);
               check_field("jump_target", want.jump_target, rsp_data.jump_target);
               check_field("top_value",   want.top_value,   rsp_data.top_value);
               check_field("stack_depth", want.stack_depth, rsp_data.stack_depth);
               check_field("char_valid",  want.char_valid,  rsp_data.char_valid);
               check_field("char_out",    want.char_out,    rsp_data.char_out);
               check_field("overflow",    want.overflow,    rsp_data.overflow);
               if (want.jump_valid) jumps_seen++;
               if (want.overflow) overflows_seen++;
               if (want.char_valid) chars_seen++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d idle cycles", stall_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int random_start;

      // Directed opening: empty stack, divide by zero, jump and call limits.
      add_instr(OP_RET, 32'd0, 16'd0);
      add_instr(OP_POP, 32'd0, 16'd1);
      add_instr(OP_DUP, 32'd0, 16'd2);
      add_instr(OP_PRINTC, 32'd0, 16'd3);
      add_instr(OP_JMP, 32'd0, 16'd4);
      add_instr(OP_PUSH, 32'd0, 16'd5);
      add_instr(OP_ADD, 32'd0, 16'd6);
      add_instr(OP_PUSH, 32'h8000_0000, 16'd7);
      add_instr(OP_DIV, 32'd0, 16'd8);
      add_instr(OP_SWAP, 32'd0, 16'd9);
      add_instr(OP_JZ, 32'd2, 16'd10);
      add_instr(OP_PUSH, 32'hFFFF_FFFF, 16'd11);
      add_instr(OP_ADD, 32'hFFFF_FFFF, 16'd12);
      add_instr(OP_DUP, 32'd0, 16'd13);
      add_instr(OP_MUL, 32'd0, 16'd14);
      add_instr(OP_SUB, 32'd0, 16'd15);
      add_instr(OP_INC, 32'd0, 16'd16);
      add_instr(OP_DEC, 32'd0, 16'd17);
      add_instr(OP_JNZ, 32'hFFFF_FFFF, 16'd18);
      add_instr(OP_JMP, 32'd2, 16'd19);
      add_instr(OP_JNZ, 32'd1, 16'd20);
      add_instr(OP_CALL, CALL_LIMIT, 16'hFFFF);
      add_instr(OP_CALL, CALL_LIMIT + 32'd1, 16'd22);
      add_instr(OP_RET, 32'd0, 16'd23);
      add_instr(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF);
      add_instr(OP_HALT, 32'd0, 16'd25);
      add_instr(OP_FIRST_SPARE, 32'd0, 16'd26);
      add_instr(OP_LAST_SPARE, 32'hFFFF_FFFF, 16'hFFFF);

      // Random programs; the first item of each new phase waits for all
      // earlier results.
      hold_next    = 1'b1;
      random_start = pending_instr.size();
      while (pending_instr.size() - random_start < RANDOM_ITEMS) begin
         if (gen_phase < 2 &&
             pending_instr.size() - random_start >= (gen_phase + 1) * RANDOM_ITEMS / 3) begin
            gen_phase++;
            hold_next = 1'b1;
         end
         add_random_segment();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sample between edges so the driver's updates have settled.
      do @(negedge clock);
      while (pending_instr.size() != 0 || req_valid || predicted_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Executed %0d instructions and checked %0d results over three idling profiles.",
               items_sent, results_seen);
      $display("Results included %0d taken jumps, %0d overflows and %0d printed characters.",
               jumps_seen, overflows_seen, chars_seen);
      if (mismatch_count == 0 && predicted_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
